// ----- hdl/clr_pkg.sv -----
// Package for the command line receiver with XOR-8 checksum.
// Holds character codes, terminator and status codes, field widths and the
// emit command that passes from the line assembler to the result sequencer.
package clr_pkg;

  localparam int BYTE_W     = 8;
  localparam int STATUS_W   = 3;
  localparam int INDEX_W    = 6;
  localparam int BODY_LEN_W = 7;

  localparam logic [BYTE_W-1:0] CH_STAR = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;

  localparam logic [1:0] TERM_NONE = 2'd0;
  localparam logic [1:0] TERM_CR   = 2'd1;
  localparam logic [1:0] TERM_LF   = 2'd2;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STATUS_PLAIN   = 3'd0;
  localparam status_t STATUS_SUM_OK  = 3'd1;
  localparam status_t STATUS_REPEAT  = 3'd2;
  localparam status_t STATUS_SUM_BAD = 3'd3;
  localparam status_t STATUS_NO_PREV = 3'd4;

  typedef struct packed {
    logic                  start;
    logic                  single;
    status_t               status;
    logic [BODY_LEN_W-1:0] len;
    logic                  bank;
  } emit_cmd_t;

endpackage

// ----- hdl/clr_if.sv -----
// Request channels of the command line receiver.
// Depends on clr_pkg for the field widths.
interface clr_in_if;
  logic                       valid;
  logic                       ready;
  logic [clr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface clr_out_if;
  logic                           valid;
  logic                           ready;
  logic [clr_pkg::STATUS_W-1:0]   line_status;
  logic [clr_pkg::BYTE_W-1:0]     body_byte;
  logic [clr_pkg::INDEX_W-1:0]    byte_index;
  logic [clr_pkg::BODY_LEN_W-1:0] body_length;
  logic                           last_of_line;

  modport source (output valid, output line_status, output body_byte, output byte_index,
                  output body_length, output last_of_line, input ready);
  modport sink (input valid, input line_status, input body_byte, input byte_index,
                input body_length, input last_of_line, output ready);
endinterface

// ----- hdl/command_line_receiver_xor_check.sv -----
// Command line receiver with XOR-8 hex checksum. Bytes arrive on rx and are
// gathered into lines ended by CR, LF or a CR LF / LF CR pair; an optional
// "*HH" suffix is checked against the XOR of the body and stripped, good bodies
// come out one byte per request on res and are kept for replay on an empty
// line. An ordinary byte or a swallowed terminator leaves rx ready. A terminator
// that produces results holds rx off until its final request is in the output
// register. Each body byte is read through the registered read port of the line
// memory before the output register; that single read port sets the rate of one
// body byte per cycle while res does not stall. The memory needs no clearing
// pass after reset.
module command_line_receiver_xor_check #(
  parameter int LINE_MAX = 64
) (
  input logic       clk,
  input logic       rst,
  clr_in_if.sink    rx,
  clr_out_if.source res
);
  import clr_pkg::*;

  localparam int AW = $clog2(LINE_MAX);
  localparam int LW = $clog2(LINE_MAX + 1);

  function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  logic [LW-1:0]     line_len;
  logic [BYTE_W-1:0] run_xor;
  logic [LW-1:0]     star_pos;
  logic [BYTE_W-1:0] xor_star;
  logic              star_seen;
  logic [BYTE_W-1:0] hex_hi;
  logic [BYTE_W-1:0] hex_lo;
  logic [1:0]        pend;
  logic              prev_bank;
  logic [LW-1:0]     prev_len;

  logic              busy;
  logic              acc;
  logic              is_term;
  logic [1:0]        term;
  logic              store;
  logic              is_star;
  logic [LW:0]       pos_wide;
  logic [LW:0]       star_wide;
  logic [4:0]        hv_hi;
  logic [4:0]        hv_lo;
  logic              ck_ok;
  logic              line_good;
  logic [LW-1:0]     blen;
  emit_cmd_t         cmd;
  logic [AW:0]       rd_addr;
  logic [BYTE_W-1:0] rd_data;

  assign rx.ready  = !busy;
  assign acc       = rx.valid && rx.ready;
  assign is_term   = (rx.rx_byte == CH_CR) || (rx.rx_byte == CH_LF);
  assign term      = (rx.rx_byte == CH_CR) ? TERM_CR : TERM_LF;
  assign is_star   = rx.rx_byte == CH_STAR;
  assign store     = acc && !is_term && (line_len < LW'(LINE_MAX));
  assign pos_wide  = (LW + 1)'(line_len);
  assign star_wide = (LW + 1)'(star_pos);
  assign hv_hi     = hex_digit(hex_hi);
  assign hv_lo     = hex_digit(hex_lo);
  assign ck_ok     = (pos_wide == star_wide + 3'd3) && hv_hi[4] && hv_lo[4] &&
                     ({hv_hi[3:0], hv_lo[3:0]} == xor_star);
  assign line_good = !star_seen || ck_ok;
  assign blen      = star_seen ? star_pos : line_len;

  always_comb begin
    cmd        = '0;
    cmd.start  = acc && is_term &&
                 ((line_len != '0) || !((pend != TERM_NONE) && (term != pend)));
    if (line_len != '0) begin
      if (!line_good) begin
        cmd.single = 1'b1;
        cmd.status = STATUS_SUM_BAD;
      end else begin
        cmd.single = blen == '0;
        cmd.status = star_seen ? STATUS_SUM_OK : STATUS_PLAIN;
        cmd.len    = BODY_LEN_W'(blen);
        cmd.bank   = !prev_bank;
      end
    end else if (prev_len == '0) begin
      cmd.single = 1'b1;
      cmd.status = STATUS_NO_PREV;
    end else begin
      cmd.status = STATUS_REPEAT;
      cmd.len    = BODY_LEN_W'(prev_len);
      cmd.bank   = prev_bank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_len  <= '0;
      run_xor   <= '0;
      star_pos  <= '0;
      xor_star  <= '0;
      star_seen <= 1'b0;
      pend      <= TERM_NONE;
      prev_bank <= 1'b0;
      prev_len  <= '0;
    end else if (acc) begin
      if (is_term) begin
        if (line_len != '0) begin
          if (line_good) begin
            prev_bank <= !prev_bank;
            prev_len  <= blen;
          end
          line_len  <= '0;
          run_xor   <= '0;
          star_pos  <= '0;
          xor_star  <= '0;
          star_seen <= 1'b0;
          pend      <= term;
        end else begin
          pend <= TERM_NONE;
        end
      end else begin
        if (store) begin
          line_len <= line_len + 1'b1;
          run_xor  <= run_xor ^ rx.rx_byte;
          if (is_star) begin
            star_seen <= 1'b1;
            star_pos  <= line_len;
            xor_star  <= run_xor;
          end
        end
        pend <= TERM_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store && !is_star && star_seen) begin
      if (pos_wide == star_wide + 1'b1) begin
        hex_hi <= rx.rx_byte;
      end
      if (pos_wide == star_wide + 2'd2) begin
        hex_lo <= rx.rx_byte;
      end
    end
  end

  clr_line_ram #(
    .ADDR_W(AW + 1)
  ) u_ram (
    .clk    (clk),
    .wr_en  (store),
    .wr_addr({!prev_bank, line_len[AW-1:0]}),
    .wr_data(rx.rx_byte),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  clr_emitter #(
    .LINE_MAX(LINE_MAX)
  ) u_emit (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .busy   (busy),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .res    (res)
  );

endmodule

// ----- hdl/clr_line_ram.sv -----
// Two-bank line memory: one bank takes the line being received, the other
// holds the previous body. One write port, one registered read port.
module clr_line_ram #(
  parameter int ADDR_W = 7
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [clr_pkg::BYTE_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [clr_pkg::BYTE_W-1:0] rd_data
);
  import clr_pkg::*;

  logic [BYTE_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/clr_emitter.sv -----
// Result sequencer: sends a single status request or reads a body out of the line
// memory one byte per cycle unless res stalls, and drives res via an output register.
// Depends on clr_pkg and clr_out_if.
module clr_emitter #(
  parameter int LINE_MAX = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  clr_pkg::emit_cmd_t         cmd,
  output logic                       busy,
  output logic [$clog2(LINE_MAX):0]  rd_addr,
  input  logic [clr_pkg::BYTE_W-1:0] rd_data,
  clr_out_if.source                  res
);
  import clr_pkg::*;

  localparam int AW = $clog2(LINE_MAX);
  localparam int LW = $clog2(LINE_MAX + 1);

  logic                  active;
  logic                  single;
  status_t               status;
  logic [BODY_LEN_W-1:0] len;
  logic                  bank;
  logic [LW-1:0]         idx;
  logic                  s1_valid;
  logic [AW-1:0]         s1_idx;
  logic                  s1_last;

  logic out_free;
  logic out_load;
  logic single_load;
  logic issue;
  logic idx_last;

  assign out_free    = !res.valid || res.ready;
  assign out_load    = s1_valid && out_free;
  assign single_load = active && single && out_free;
  assign issue       = active && !single && (!s1_valid || out_load);
  assign idx_last    = (BODY_LEN_W'(idx) + 1'b1) == len;
  assign busy        = active || s1_valid;
  assign rd_addr     = {bank, issue ? idx[AW-1:0] : s1_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      s1_valid  <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (cmd.start) begin
        active <= 1'b1;
      end else if (single_load) begin
        active <= 1'b0;
      end else if (issue && idx_last) begin
        active <= 1'b0;
      end

      if (issue) begin
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end

      if (single_load || out_load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      single <= cmd.single;
      status <= cmd.status;
      len    <= cmd.len;
      bank   <= cmd.bank;
      idx    <= '0;
    end else if (issue) begin
      idx <= idx + 1'b1;
    end

    if (issue) begin
      s1_idx  <= idx[AW-1:0];
      s1_last <= idx_last;
    end

    if (single_load) begin
      res.line_status  <= status;
      res.body_byte    <= '0;
      res.byte_index   <= '0;
      res.body_length  <= '0;
      res.last_of_line <= 1'b1;
    end else if (out_load) begin
      res.line_status  <= status;
      res.body_byte    <= rd_data;
      res.byte_index   <= INDEX_W'(s1_idx);
      res.body_length  <= len;
      res.last_of_line <= s1_last;
    end
  end

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !busy) else $error("line command issued while sequencer busy");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.body_length == '0 |-> res.last_of_line)
    else $error("empty-body request not marked last");

  a_index_in_body: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.body_length != '0 |-> BODY_LEN_W'(res.byte_index) < res.body_length)
    else $error("byte index outside body");

  a_no_read_for_single: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !(active && single)) else $error("memory read during single request");

endmodule

// ----- tb/tb_command_line_receiver_xor_check.sv -----
// Testbench for the command line receiver with XOR-8 checksum. A directed table and then
// random lines are sent, each result request checked against the table or a line predictor.
// Depends on clr_pkg, the clr_in_if and clr_out_if interfaces and the receiver RTL.
`timescale 1ns / 1ps

module tb_command_line_receiver_xor_check;
  import clr_pkg::*;

  localparam int LINE_MAX     = 64;
  localparam int RANDOM_CHARS = 360;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 70;

  typedef struct packed {
    status_t               status;
    logic [BYTE_W-1:0]     body_byte;
    logic [INDEX_W-1:0]    byte_index;
    logic [BODY_LEN_W-1:0] body_length;
    logic                  last_of_line;
  } line_result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              typed;
    line_result_t      result;
  } rx_row_t;

  localparam line_result_t NO_RESULT      = '0;
  localparam line_result_t NO_PREV_RESULT = '{STATUS_NO_PREV, 8'h00, 6'd0, 7'd0, 1'b1};
  localparam line_result_t SUM_BAD_RESULT = '{STATUS_SUM_BAD, 8'h00, 6'd0, 7'd0, 1'b1};
  localparam line_result_t EMPTY_OK_RESULT = '{STATUS_SUM_OK, 8'h00, 6'd0, 7'd0, 1'b1};

  localparam int DIRECTED_ROWS = 23;
  localparam rx_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{CH_CR,   1'b1, NO_PREV_RESULT},
    '{8'h00,   1'b0, NO_RESULT},
    '{8'hFF,   1'b0, NO_RESULT},
    '{8'h41,   1'b0, NO_RESULT},
    '{CH_CR,   1'b0, NO_RESULT},
    '{CH_LF,   1'b0, NO_RESULT},
    '{CH_LF,   1'b0, NO_RESULT},
    '{CH_STAR, 1'b0, NO_RESULT},
    '{8'h30,   1'b0, NO_RESULT},
    '{8'h30,   1'b0, NO_RESULT},
    '{CH_LF,   1'b1, EMPTY_OK_RESULT},
    '{CH_CR,   1'b0, NO_RESULT},
    '{CH_CR,   1'b1, NO_PREV_RESULT},
    '{8'h5A,   1'b0, NO_RESULT},
    '{CH_STAR, 1'b0, NO_RESULT},
    '{8'h35,   1'b0, NO_RESULT},
    '{8'h61,   1'b0, NO_RESULT},
    '{CH_CR,   1'b0, NO_RESULT},
    '{CH_STAR, 1'b0, NO_RESULT},
    '{8'h47,   1'b0, NO_RESULT},
    '{8'h31,   1'b0, NO_RESULT},
    '{CH_LF,   1'b1, SUM_BAD_RESULT},
    '{CH_LF,   1'b0, NO_RESULT}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #4 clk = ~clk;

  clr_in_if rx ();
  clr_out_if res ();

  command_line_receiver_xor_check #(.LINE_MAX(LINE_MAX)) dut (
    .clk(clk),
    .rst(rst),
    .rx(rx),
    .res(res)
  );

  logic [BYTE_W-1:0] line_chars [LINE_MAX];
  int unsigned       line_len = 0;
  logic [1:0]        term_pending = TERM_NONE;
  logic [BYTE_W-1:0] xor_all = '0;
  int unsigned       star_at = 0;
  logic [BYTE_W-1:0] xor_at_star = '0;
  bit                star_found = 1'b0;
  logic [BYTE_W-1:0] prev_chars [LINE_MAX];
  int unsigned       prev_len = 0;
  bit                char_ignored;
  line_result_t      fresh_results [$];
  line_result_t      results_due [$];

  int failures = 0;
  int chars_counted = 0;
  int idle_cycles = 0;
  int res_wait = 0;
  bit rx_steady = 1'b0;
  bit res_steady = 1'b0;

  function automatic int hex_nibble(input logic [BYTE_W-1:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    return -1;
  endfunction

  function automatic void queue_body(input status_t st, input int unsigned len);
    line_result_t r;
    if (len == 0) begin
      r = '{st, 8'h00, 6'd0, 7'd0, 1'b1};
      fresh_results.push_back(r);
    end else begin
      for (int i = 0; i < len; i++) begin
        r.status       = st;
        r.body_byte    = prev_chars[i];
        r.byte_index   = INDEX_W'(i);
        r.body_length  = BODY_LEN_W'(len);
        r.last_of_line = (i + 1 == len);
        fresh_results.push_back(r);
      end
    end
  endfunction

  function automatic void receive_char(input logic [BYTE_W-1:0] ch);
    logic [1:0]  term;
    int          hi;
    int          lo;
    bit          sum_ok;
    int unsigned body_len;
    status_t     st;
    fresh_results.delete();
    char_ignored = 1'b0;
    if (ch == CH_CR || ch == CH_LF) begin
      term = (ch == CH_CR) ? TERM_CR : TERM_LF;
      if (line_len > 0) begin
        st = STATUS_PLAIN;
        body_len = line_len;
        sum_ok = 1'b1;
        if (star_found) begin
          sum_ok = (line_len == star_at + 3);
          if (sum_ok) begin
            hi = hex_nibble(line_chars[star_at + 1]);
            lo = hex_nibble(line_chars[star_at + 2]);
            sum_ok = hi >= 0 && lo >= 0 && BYTE_W'(hi * 16 + lo) == xor_at_star;
          end
          st = STATUS_SUM_OK;
          body_len = star_at;
        end
        if (sum_ok) begin
          for (int i = 0; i < body_len; i++) prev_chars[i] = line_chars[i];
          prev_len = body_len;
          queue_body(st, body_len);
        end else begin
          queue_body(STATUS_SUM_BAD, 0);
        end
        line_len = 0;
        xor_all = '0;
        star_at = 0;
        xor_at_star = '0;
        star_found = 1'b0;
        term_pending = term;
      end else if (term_pending != TERM_NONE && term != term_pending) begin
        term_pending = TERM_NONE;
        char_ignored = 1'b1;
      end else begin
        term_pending = TERM_NONE;
        queue_body((prev_len == 0) ? STATUS_NO_PREV : STATUS_REPEAT, prev_len);
      end
    end else begin
      if (line_len < LINE_MAX) begin
        if (ch == CH_STAR) begin
          star_found = 1'b1;
          star_at = line_len;
          xor_at_star = xor_all;
        end
        line_chars[line_len] = ch;
        line_len++;
        xor_all ^= ch;
      end else begin
        char_ignored = 1'b1;
      end
      term_pending = TERM_NONE;
    end
  endfunction

  function automatic logic [BYTE_W-1:0] body_char(input bit allow_star);
    logic [BYTE_W-1:0] c;
    do c = BYTE_W'($urandom_range(0, 255));
    while (c == CH_CR || c == CH_LF || (!allow_star && c == CH_STAR));
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'h30 + n;
    return (upper ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $error("%s expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  task automatic send_char(input logic [BYTE_W-1:0] ch, input bit typed = 1'b0,
                           input line_result_t typed_result = '0);
    int gap;
    if ($urandom_range(0, 29) == 0) rx_steady = !rx_steady;
    gap = rx_steady ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx.valid <= 1'b1;
    rx.rx_byte <= ch;
    do @(posedge clk); while (rx.ready !== 1'b1);
    receive_char(ch);
    if (typed) begin
      results_due.push_back(typed_result);
    end else begin
      foreach (fresh_results[i]) results_due.push_back(fresh_results[i]);
    end
    if (!char_ignored) chars_counted++;
  endtask

  task automatic send_terminator();
    case ($urandom_range(0, 5))
      0, 1: send_char(CH_CR);
      2, 3: send_char(CH_LF);
      4: begin
        send_char(CH_CR);
        send_char(CH_LF);
      end
      default: begin
        send_char(CH_LF);
        send_char(CH_CR);
      end
    endcase
  endtask

  task automatic send_checked_line(input int len);
    logic [BYTE_W-1:0] c;
    logic [BYTE_W-1:0] sum;
    bit                star_inside;
    bit                upper;
    int                flaw;
    sum = '0;
    star_inside = ($urandom_range(0, 9) == 0);
    upper = 1'($urandom_range(0, 1));
    flaw = $urandom_range(0, 9);
    repeat (len) begin
      c = body_char(star_inside);
      sum ^= c;
      send_char(c);
    end
    send_char(CH_STAR);
    if (flaw == 7) sum ^= BYTE_W'(1 << $urandom_range(0, 7));
    send_char(hex_char(sum[7:4], upper));
    if (flaw == 8) send_char(body_char(1'b0));
    else if (flaw != 6) send_char(hex_char(sum[3:0], upper));
    if (flaw == 9) send_char(hex_char(sum[3:0], !upper));
    send_terminator();
  endtask

  task automatic send_random_line();
    int kind;
    int len;
    kind = $urandom_range(0, 99);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 61) : $urandom_range(1, 8);
    if (kind < 40) begin
      repeat (len) send_char(body_char(1'b0));
      send_terminator();
    end else if (kind < 75) begin
      send_checked_line(($urandom_range(0, 8) == 0) ? 0 : len);
    end else if (kind < 85) begin
      send_terminator();
    end else if (kind < 95) begin
      repeat ($urandom_range(1, 6)) send_char(BYTE_W'($urandom_range(0, 255)));
    end else if ($urandom_range(0, 1) == 1) begin
      send_checked_line(61);
    end else begin
      repeat ($urandom_range(60, 72)) send_char(body_char(1'b0));
      send_terminator();
    end
  endtask

  always @(negedge clk) begin
    if (res_wait > 0) begin
      res.ready <= 1'b0;
      res_wait--;
    end else begin
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    line_result_t want;
    if (!rst && res.valid === 1'b1 && res.ready === 1'b1) begin
      if (results_due.size() == 0) begin
        $error("unexpected result request: status %0d, byte %0d, index %0d",
               res.line_status, res.body_byte, res.byte_index);
        failures++;
      end else begin
        want = results_due.pop_front();
        compare_field("line_status", 8'(want.status), 8'(res.line_status));
        compare_field("body_byte", want.body_byte, res.body_byte);
        compare_field("byte_index", 8'(want.byte_index), 8'(res.byte_index));
        compare_field("body_length", 8'(want.body_length), 8'(res.body_length));
        compare_field("last_of_line", 8'(want.last_of_line), 8'(res.last_of_line));
      end
      if ($urandom_range(0, 29) == 0) res_steady = !res_steady;
      res_wait = res_steady ? 0 : $urandom_range(0, 10);
    end
  end

  always @(posedge clk) begin
    if ((rx.valid === 1'b1 && rx.ready === 1'b1) ||
        (res.valid === 1'b1 && res.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rx.valid = 1'b0;
    rx.rx_byte = '0;
    res.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (DIRECTED[i]) send_char(DIRECTED[i].ch, DIRECTED[i].typed, DIRECTED[i].result);
    chars_counted = 0;
    while (chars_counted < RANDOM_CHARS) send_random_line();
    @(negedge clk);
    rx.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && results_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
